/* sv/command_frame_register_decoder_core_defines.svh */
// ----------------------------------------------------------------------------
// command frame register decoder - assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_REGISTER_DECODER_CORE_DEFINES_SVH
`define COMMAND_FRAME_REGISTER_DECODER_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define CFRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define CFRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/cfrd_pkg.sv */
// ----------------------------------------------------------------------------
// cfrd_pkg
// constants shared by the command frame register decoder
// ----------------------------------------------------------------------------
package cfrd_pkg;

  localparam int NUM_CHANNELS = 8;

  localparam logic [7:0]  START_MARK     = 8'h55;
  localparam logic [7:0]  END_MARK       = 8'hAA;
  localparam logic [15:0] POSITION_RESET = 16'd1000;
  localparam logic [15:0] ERROR_MAX      = 16'hFFFF;

endpackage

/* sv/command_frame_register_decoder_core.sv */
// ----------------------------------------------------------------------------
// command_frame_register_decoder_core
// assembles 5-byte command frames and writes keyed position registers
// ----------------------------------------------------------------------------
// One received byte per input beat, one result beat per input beat. Frames
// are 0x55, key, value high, value low, 0xAA; a good frame with a key below
// NUM_CHANNELS writes the 16-bit value to that position register (reset 1000).
// Bad start bytes are dropped and bad end markers discard the frame; both
// bump a saturating 16-bit error total. Each result also returns the queried
// position register as it stands after the byte, including a write made by
// that same byte. The result beat is registered and valid in the cycle after its input
// beat is accepted, and a new byte is taken every cycle while the result register is empty
// or being drained; throughput is set only by the single result register stage.
module command_frame_register_decoder_core
  import cfrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic [2:0]  query_channel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_complete,
  output logic        register_updated,
  output logic [2:0]  updated_channel,
  output logic        start_error,
  output logic        end_error,
  output logic [15:0] error_total,
  output logic [15:0] query_position
);

  typedef enum logic [2:0] {
    POS_START,
    POS_KEY,
    POS_HIGH,
    POS_LOW,
    POS_END
  } pos_t;

  pos_t        frame_position, frame_position_next;
  logic [7:0]  held_key;
  logic [7:0]  held_value_high;
  logic [7:0]  held_value_low;
  logic [15:0] position_store [NUM_CHANNELS];
  logic [15:0] error_counter, error_counter_next;

  logic        accept;
  logic        complete_c, updated_c, serr_c, eerr_c;
  logic [15:0] value_c;
  logic [15:0] qpos_c;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign value_c  = {held_value_high, held_value_low};

  always_comb begin
    frame_position_next = frame_position;
    complete_c = 1'b0;
    updated_c  = 1'b0;
    serr_c     = 1'b0;
    eerr_c     = 1'b0;
    case (frame_position)
      POS_START: begin
        if (rx_byte == START_MARK) begin
          frame_position_next = POS_KEY;
        end else begin
          serr_c = 1'b1;
        end
      end
      POS_KEY:  frame_position_next = POS_HIGH;
      POS_HIGH: frame_position_next = POS_LOW;
      POS_LOW:  frame_position_next = POS_END;
      POS_END: begin
        complete_c = 1'b1;
        frame_position_next = POS_START;
        if (rx_byte == END_MARK) begin
          updated_c = ({1'b0, held_key} < 9'(NUM_CHANNELS));
        end else begin
          eerr_c = 1'b1;
        end
      end
      default: frame_position_next = POS_START;
    endcase
  end

  always_comb begin
    error_counter_next = error_counter;
    if ((serr_c || eerr_c) && error_counter != ERROR_MAX) begin
      error_counter_next = error_counter + 16'd1;
    end
  end

  // read-back sees a write made by the same byte
  always_comb begin
    qpos_c = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if ({5'b0, query_channel} == 8'(i)) begin
        if (updated_c && held_key == 8'(i)) begin
          qpos_c = value_c;
        end else begin
          qpos_c = position_store[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= POS_START;
      error_counter  <= '0;
      out_valid      <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        position_store[i] <= POSITION_RESET;
      end
    end else begin
      if (accept) begin
        frame_position <= frame_position_next;
        error_counter  <= error_counter_next;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (updated_c && held_key == 8'(i)) begin
            position_store[i] <= value_c;
          end
        end
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame bytes and result beat payload
  always_ff @(posedge clk) begin
    if (accept) begin
      case (frame_position)
        POS_KEY:  held_key        <= rx_byte;
        POS_HIGH: held_value_high <= rx_byte;
        POS_LOW:  held_value_low  <= rx_byte;
        default:  ;
      endcase
      frame_complete   <= complete_c;
      register_updated <= updated_c;
      updated_channel  <= updated_c ? held_key[2:0] : 3'd0;
      start_error      <= serr_c;
      end_error        <= eerr_c;
      error_total      <= error_counter_next;
      query_position   <= qpos_c;
    end
  end

endmodule

/* sv/cfrd_checker.sv */
// ----------------------------------------------------------------------------
// cfrd_checker
// port-level checks on the command frame register decoder
// ----------------------------------------------------------------------------
`include "command_frame_register_decoder_core_defines.svh"

module cfrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  rx_byte,
  input logic [2:0]  query_channel,
  input logic        out_valid,
  input logic        out_ready,
  input logic        frame_complete,
  input logic        register_updated,
  input logic [2:0]  updated_channel,
  input logic        start_error,
  input logic        end_error,
  input logic [15:0] error_total,
  input logic [15:0] query_position
);

  // a write only comes from a good fifth byte
  `CFRD_ASSERT_NOW(a_update_on_good_end, out_valid && register_updated, frame_complete && !end_error && !start_error, "register update without a good end marker")

  // a dropped start byte never closes a frame
  `CFRD_ASSERT_NOW(a_start_err_no_frame, out_valid && start_error, !frame_complete && !end_error && !register_updated, "start error beat also reports frame activity")

  // error total never goes backwards between result beats
  `CFRD_ASSERT_NOW(a_err_total_monotonic, out_valid && $past(out_valid) && !$past(rst), error_total >= $past(error_total), "error total decreased")

  // a stalled result beat holds
  `CFRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(query_position) && $stable(error_total), "stalled result beat changed")

endmodule

bind command_frame_register_decoder_core cfrd_checker u_cfrd_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command frame register decoder testbench
// drives received bytes with query channels into the decoder, predicts every
// result beat from its own copy of the frame state and position registers,
// and checks each field as results are drained under random stalls
// ----------------------------------------------------------------------------

typedef struct packed {
  logic        frame_complete;
  logic        register_updated;
  logic [2:0]  updated_channel;
  logic        start_error;
  logic        end_error;
  logic [15:0] error_total;
  logic [15:0] query_position;
} decode_beat_t;

class frame_decode_tracker;

  bit [2:0]     frame_pos;
  bit [7:0]     key_byte;
  bit [7:0]     value_hi;
  bit [7:0]     value_lo;
  bit [15:0]    position_reg [cfrd_pkg::NUM_CHANNELS];
  bit [15:0]    error_count;
  decode_beat_t pending_decodes [$];
  int           failures;

  function new();
    frame_pos   = '0;
    key_byte    = '0;
    value_hi    = '0;
    value_lo    = '0;
    error_count = '0;
    failures    = 0;
    foreach (position_reg[i]) position_reg[i] = cfrd_pkg::POSITION_RESET;
  endfunction

  function void bump_errors();
    if (error_count != cfrd_pkg::ERROR_MAX) error_count = error_count + 16'd1;
  endfunction

  // accepted input beat: advance the frame state and queue the result it causes
  function void take_byte(bit [7:0] rx, bit [2:0] query);
    decode_beat_t want;
    want = '0;
    case (frame_pos)
      3'd0: begin
        if (rx != cfrd_pkg::START_MARK) begin
          want.start_error = 1'b1;
          bump_errors();
        end else begin
          frame_pos = 3'd1;
        end
      end
      3'd1: begin
        key_byte  = rx;
        frame_pos = 3'd2;
      end
      3'd2: begin
        value_hi  = rx;
        frame_pos = 3'd3;
      end
      3'd3: begin
        value_lo  = rx;
        frame_pos = 3'd4;
      end
      default: begin
        want.frame_complete = 1'b1;
        if (rx == cfrd_pkg::END_MARK) begin
          // keys past the last channel are silently ignored
          if (int'(key_byte) < cfrd_pkg::NUM_CHANNELS) begin
            position_reg[key_byte[2:0]] = {value_hi, value_lo};
            want.register_updated       = 1'b1;
            want.updated_channel        = key_byte[2:0];
          end
        end else begin
          want.end_error = 1'b1;
          bump_errors();
        end
        frame_pos = 3'd0;
      end
    endcase
    want.error_total = error_count;
    // read back after any write made by this same byte
    if (int'(query) < cfrd_pkg::NUM_CHANNELS) want.query_position = position_reg[query];
    pending_decodes.push_back(want);
  endfunction

  function void flag(string field, int unsigned want, int unsigned seen);
    failures++;
    if (failures <= 100)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
  endfunction

  function void check_decode(decode_beat_t seen);
    decode_beat_t want;
    if (pending_decodes.size() == 0) begin
      failures++;
      if (failures <= 100)
        $display("%0t: result beat with none expected, expected nothing, actual %0h",
                 $time, seen);
      return;
    end
    want = pending_decodes.pop_front();
    if (seen.frame_complete !== want.frame_complete)
      flag("frame_complete", want.frame_complete, seen.frame_complete);
    if (seen.register_updated !== want.register_updated)
      flag("register_updated", want.register_updated, seen.register_updated);
    if (seen.updated_channel !== want.updated_channel)
      flag("updated_channel", want.updated_channel, seen.updated_channel);
    if (seen.start_error !== want.start_error)
      flag("start_error", want.start_error, seen.start_error);
    if (seen.end_error !== want.end_error)
      flag("end_error", want.end_error, seen.end_error);
    if (seen.error_total !== want.error_total)
      flag("error_total", want.error_total, seen.error_total);
    if (seen.query_position !== want.query_position)
      flag("query_position", want.query_position, seen.query_position);
  endfunction

endclass

module testbench;
  import cfrd_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic [2:0]  query_channel;
  logic        out_valid;
  logic        out_ready;
  logic        frame_complete;
  logic        register_updated;
  logic [2:0]  updated_channel;
  logic        start_error;
  logic        end_error;
  logic [15:0] error_total;
  logic [15:0] query_position;

  frame_decode_tracker tracker;
  decode_beat_t        seen_beat;
  bit                  steady;
  int                  bytes_sent;
  int                  quiet_cycles;

  command_frame_register_decoder_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .rx_byte          (rx_byte),
    .query_channel    (query_channel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .frame_complete   (frame_complete),
    .register_updated (register_updated),
    .updated_channel  (updated_channel),
    .start_error      (start_error),
    .end_error        (end_error),
    .error_total      (error_total),
    .query_position   (query_position)
  );

  always #5 clk = ~clk;

  // result side stalls at random unless in a steady stretch
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && in_ready) tracker.take_byte(rx_byte, query_channel);
      if (out_valid && out_ready) begin
        seen_beat = {frame_complete, register_updated, updated_channel, start_error,
                     end_error, error_total, query_position};
        tracker.check_decode(seen_beat);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // starts and ends at a falling edge; ends just after the beat is taken
  task send_byte(input logic [7:0] rx, input logic [2:0] query);
    if (!steady) begin
      while ($urandom_range(99) < 28) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid      <= 1'b1;
    rx_byte       <= rx;
    query_channel <= query;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task send_frame(input logic [7:0] key, input logic [7:0] hi, input logic [7:0] lo,
                  input logic [7:0] tail);
    send_byte(START_MARK, 3'($urandom_range(7)));
    send_byte(key, 3'($urandom_range(7)));
    send_byte(hi, 3'($urandom_range(7)));
    send_byte(lo, 3'($urandom_range(7)));
    // query the keyed channel half the time to catch same-beat write and read
    send_byte(tail, ($urandom_range(1) == 1) ? key[2:0] : 3'($urandom_range(7)));
  endtask

  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == START_MARK);
    return b;
  endfunction

  initial begin
    logic [7:0] key;
    logic [7:0] tail;
    int         pick;

    tracker       = new();
    steady        = 1'b0;
    bytes_sent    = 0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    rx_byte       = '0;
    query_channel = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: bad starts, field extremes, top key, out-of-range key, bad end
    send_byte(8'h00, 3'd0);
    send_byte(8'hFF, 3'd7);
    send_byte(END_MARK, 3'd5);
    send_frame(8'h00, 8'hFF, 8'hFF, END_MARK);
    send_frame(8'h07, 8'h00, 8'h00, END_MARK);
    send_frame(8'h08, 8'h12, 8'h34, END_MARK);
    send_frame(8'h03, 8'h12, 8'h34, START_MARK);

    // random: mostly well-formed frames, some noise and misaligned fragments
    steady = 1'b1;
    while (bytes_sent < 1500) begin
      if (bytes_sent > 430) steady = 1'b0;
      pick = $urandom_range(99);
      if (pick < 80) begin
        key  = ($urandom_range(99) < 85) ? 8'($urandom_range(7)) : 8'($urandom_range(255, 8));
        tail = ($urandom_range(99) < 90) ? END_MARK : 8'($urandom);
        send_frame(key, 8'($urandom), 8'($urandom), tail);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) send_byte(stray_byte(), 3'($urandom_range(7)));
      end else begin
        send_byte(START_MARK, 3'($urandom_range(7)));
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 3'($urandom_range(7)));
      end
    end

    // closing noise, then a bad end, a good end and a near-miss end marker
    repeat (10) send_byte(stray_byte(), 3'($urandom_range(7)));
    send_frame(8'h02, 8'hAB, 8'hCD, 8'h00);
    send_frame(8'h02, 8'hAB, 8'hCD, END_MARK);
    send_frame(8'h05, 8'h80, 8'h01, 8'hA9);

    in_valid <= 1'b0;
    while (tracker.pending_decodes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/cfrd_pkg.sv
sv/command_frame_register_decoder_core.sv
sv/cfrd_checker.sv
dv/testbench.sv
